FILE: hw/rtl/aasc_pkg.sv
package aasc_pkg;

  // Grid geometry: GRID_SIZE columns by GRID_SIZE rows of cells.
  localparam int GRID_SIZE = 256;
  localparam int COORD_W   = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int ADDR_W    = 2 * COORD_W;

  // Port coordinate width and a width that can compare it against the grid.
  localparam int IN_W  = 8;
  localparam int CMP_W = ((COORD_W > IN_W) ? COORD_W : IN_W) + 1;

  // Cell counts saturate at the cell maximum.
  localparam int                CELL_W   = 16;
  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  // One corner product and the saturating total.
  localparam int PAIR_W  = 2 * CELL_W;
  localparam int PROD_W  = 3 * CELL_W;
  localparam int COUNT_W = 59;

  // Item modes.
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_COUNT = 1'b1;

endpackage

FILE: hw/rtl/aasc_cell_ram.sv
module aasc_cell_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/axis_aligned_square_counter.sv
// Axis-aligned square counter. The block keeps a count of points for every
// cell of a GRID_SIZE x GRID_SIZE grid in one single-port synchronous RAM.
// An add transaction (mode 0) bumps the cell at (x, y), saturating at 65535,
// and returns nothing; a point outside the grid is dropped. A count
// transaction (mode 1) walks every row y2 of the query column and, for
// each side length d = |y2 - y1|, multiplies the counts of the three other
// corners on the left and right squares, returning one saturated 59-bit
// total. The walk is bound by the single RAM port: the query row itself is
// skipped, a row whose column cell is empty reads no further cells, and the
// corners of each neighboring square inside the grid are read one after
// another. A query point outside the grid answers zero. After reset the
// block sweeps all 2^(2 * ceil(log2 GRID_SIZE)) RAM cells clear (65536 at
// GRID_SIZE = 256), one cell per cycle, and holds in_ready_o low meanwhile.
// The result sits in an output register, so a new transaction is taken
// while the previous total waits for out_ready_i.
module axis_aligned_square_counter
  import aasc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [IN_W-1:0]    x_coord_i,
  input  logic [IN_W-1:0]    y_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COUNT_W-1:0] square_count_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_ROW,
    S_CHK,
    S_L1,
    S_L2,
    S_R1,
    S_R2,
    S_FIN,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [ADDR_W-1:0]    clr_q;
  logic [COORD_W-1:0]   x1_q, y1_q, y2_q;
  logic [CELL_W-1:0]    c12_q;
  logic [PAIR_W-1:0]    p1_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 prod_v_q;
  logic [COUNT_W-1:0]   acc_q;
  logic                 out_valid_q;
  logic [COUNT_W-1:0]   out_data_q;

  // RAM port
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [CELL_W-1:0]    mem_rdata;

  // Incoming point, cut to grid coordinates once known to be in range.
  logic                 in_fire;
  logic                 in_ok;
  logic [COORD_W-1:0]   x_in, y_in;

  // Neighbor columns for the current row.
  logic [COORD_W-1:0]   dy;
  logic [COORD_W-1:0]   xl, xr;
  logic [COORD_W:0]     xr_w;
  logic                 left_ok, right_ok;
  logic                 last_row;

  // Saturating accumulate.
  logic [COUNT_W:0]     sum_w;
  logic [COUNT_W-1:0]   sum_sat;

  assign in_ready_o     = (state_q == S_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign in_ok          = (CMP_W'(x_coord_i) < CMP_W'(GRID_SIZE)) &&
                          (CMP_W'(y_coord_i) < CMP_W'(GRID_SIZE));
  assign x_in           = COORD_W'(x_coord_i);
  assign y_in           = COORD_W'(y_coord_i);

  assign dy             = (y2_q > y1_q) ? (y2_q - y1_q) : (y1_q - y2_q);
  assign left_ok        = (x1_q >= dy);
  assign xl             = x1_q - dy;
  assign xr_w           = {1'b0, x1_q} + {1'b0, dy};
  assign right_ok       = (xr_w < (COORD_W + 1)'(GRID_SIZE));
  assign xr             = xr_w[COORD_W-1:0];
  assign last_row       = (y2_q == COORD_W'(GRID_SIZE - 1));

  assign sum_w          = (COUNT_W + 1)'(acc_q) + (COUNT_W + 1)'(prod_q);
  assign sum_sat        = sum_w[COUNT_W] ? '1 : sum_w[COUNT_W-1:0];

  assign out_valid_o    = out_valid_q;
  assign square_count_o = out_data_q;

  // Pick the RAM access for this cycle; read data returns in the next state.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = mem_rdata + CELL_W'(1);
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      S_IDLE:  mem_addr = {x_in, y_in};
      S_ADD: begin
        // Read-modify-write of the cell read on the accepting edge.
        mem_we   = (mem_rdata != CELL_MAX);
        mem_addr = {x1_q, y1_q};
      end
      S_ROW:   mem_addr = {x1_q, y2_q};
      S_CHK:   mem_addr = left_ok ? {xl, y2_q} : {xr, y2_q};
      S_L1:    mem_addr = {xl, y1_q};
      S_L2:    mem_addr = {xr, y2_q};
      S_R1:    mem_addr = {xr, y1_q};
      default: mem_addr = '0;
    endcase
  end

  aasc_cell_ram #(
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      x1_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      acc_q       <= '0;
    end else begin
      // Absorb the product finished last cycle.
      prod_v_q <= 1'b0;
      if (prod_v_q) begin
        acc_q <= sum_sat;
      end
      // Drop the result once the consumer takes it.
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            x1_q <= x_in;
            y1_q <= y_in;
            y2_q <= '0;
            if (mode_i == MODE_ADD) begin
              state_q <= in_ok ? S_ADD : S_IDLE;
            end else begin
              acc_q   <= '0;
              state_q <= in_ok ? S_ROW : S_DONE;
            end
          end
        end
        S_ADD:   state_q <= S_IDLE;
        S_ROW: begin
          if (y2_q == y1_q) begin
            // The query row itself forms no square: advance.
            if (last_row) begin
              state_q <= S_FIN;
            end else begin
              y2_q <= y2_q + COORD_W'(1);
            end
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          c12_q <= mem_rdata;
          if ((mem_rdata == '0) || (!left_ok && !right_ok)) begin
            y2_q    <= last_row ? y2_q : y2_q + COORD_W'(1);
            state_q <= last_row ? S_FIN : S_ROW;
          end else begin
            state_q <= left_ok ? S_L1 : S_R1;
          end
        end
        S_L1: begin
          p1_q    <= PAIR_W'(c12_q) * PAIR_W'(mem_rdata);
          state_q <= S_L2;
        end
        S_L2: begin
          prod_q   <= PROD_W'(p1_q) * PROD_W'(mem_rdata);
          prod_v_q <= 1'b1;
          if (right_ok) begin
            state_q <= S_R1;
          end else begin
            y2_q    <= last_row ? y2_q : y2_q + COORD_W'(1);
            state_q <= last_row ? S_FIN : S_ROW;
          end
        end
        S_R1: begin
          p1_q    <= PAIR_W'(c12_q) * PAIR_W'(mem_rdata);
          state_q <= S_R2;
        end
        S_R2: begin
          prod_q   <= PROD_W'(p1_q) * PROD_W'(mem_rdata);
          prod_v_q <= 1'b1;
          y2_q     <= last_row ? y2_q : y2_q + COORD_W'(1);
          state_q  <= last_row ? S_FIN : S_ROW;
        end
        // Let the last product drain into the total.
        S_FIN:   state_q <= S_DONE;
        S_DONE: begin
          // Hold the total until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_data_q  <= acc_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/aasc_checker.sv
module aasc_checker
  import aasc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               mode_i,
  input logic [IN_W-1:0]    x_coord_i,
  input logic [IN_W-1:0]    y_coord_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] square_count_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(square_count_o))
    else $error("result changed while stalled");

  // An add transaction never creates a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_ADD) && !out_valid_o
    |=> !out_valid_o)
    else $error("add transaction produced a result");

  // A count transaction holds off input in the cycle after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_COUNT) |=> !in_ready_o)
    else $error("count transaction did not hold off input");

endmodule

bind axis_aligned_square_counter aasc_checker u_aasc_checker (.*);
